FILE: design/differential_drive_odometry_assert.svh
// ----------------------------------------------------------------------------
// Differential drive odometry assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ddo assertion failed");

// next-cycle implication
`define DDO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ddo assertion failed");

`endif

FILE: design/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared constants, command types and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int CountWidth  = 32;
  localparam int CordicSteps = 24;
  localparam int IterWidth   = $clog2(CordicSteps);
  localparam int CfgWidth    = 48;
  localparam int IdxWidth    = 3;

  localparam longint Deg180    = 64'sd754974720;
  localparam longint Deg360    = 64'sd1509949440;
  localparam longint Q23Deg90  = 64'sd754974720;
  localparam longint Q23Deg180 = 64'sd1509949440;
  localparam longint Q23Deg360 = 64'sd3019898880;
  localparam longint Deg2RadQ30 = 64'sd18740330;
  localparam longint CordicKinv = 64'sd652032874;

  typedef enum logic [IdxWidth-1:0] {
    REG_TRAVEL_L,
    REG_TRAVEL_R,
    REG_TURN_L,
    REG_TURN_R,
    REG_START_HEAD,
    REG_START_X,
    REG_START_Y
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_PRIME,
    OP_LOAD,
    OP_MTR,
    OP_MTL,
    OP_MVR,
    OP_MVL,
    OP_HEAD,
    OP_ANGLE,
    OP_MRAD,
    OP_CINIT,
    OP_CSTEP,
    OP_MXH,
    OP_MXL,
    OP_MYH,
    OP_MYL,
    OP_SUM1,
    OP_SUM2,
    OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MTR,
    S_MTL,
    S_MVR,
    S_MVL,
    S_HEAD,
    S_ANGLE,
    S_MRAD,
    S_CINIT,
    S_CSTEP,
    S_MXH,
    S_MXL,
    S_MYH,
    S_MYL,
    S_SUM1,
    S_SUM2,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic [IterWidth-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic primed;
  } dp_status_t;

  function automatic logic signed [31:0] atan_q30(input logic [IterWidth-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      5'd24:   v = 32'sh0000003F;
      5'd25:   v = 32'sh0000001F;
      5'd26:   v = 32'sh0000000F;
      5'd27:   v = 32'sh00000008;
      5'd28:   v = 32'sh00000004;
      5'd29:   v = 32'sh00000002;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
    logic signed [47:0] r;
    if (v > 58'sh7FFFFFFFFFFF) begin
      r = 48'sh7FFFFFFFFFFF;
    end else if (v < -58'sh800000000000) begin
      r = 48'sh800000000000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Integrates wheel encoder samples into x, y, heading and travelled distance.
// ----------------------------------------------------------------------------
// One encoder sample is taken at a time; s_axis_tready is high only while the
// block is idle. The first sample after reset primes the count reference and
// the start pose, and returns that pose through the output state. Every later
// sample runs from acceptance to a loaded result through nine steps on the
// single shared 34x34 multiplier, heading and angle reduction, 24 iterations
// of the one CORDIC stage, and two accumulate steps. The result register lets
// the next sample be accepted while the previous pose waits on m_axis_tready.
`default_nettype none
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [ddo_pkg::IdxWidth-1:0] cfg_idx_i,
  input  wire  [ddo_pkg::CfgWidth-1:0] cfg_data_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [63:0]                  s_axis_tdata,  // left_count, right_count
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [175:0]                 m_axis_tdata   // pos_x, pos_y, heading, distance
);
  import ddo_pkg::*;

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic signed [47:0] pos_x, pos_y, distance;
  logic signed [30:0] heading;

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ddo_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .left_count_i  (s_axis_tdata[31:0]),
    .right_count_i (s_axis_tdata[63:32]),
    .cmd_i         (cmd),
    .status_o      (status),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .heading_o     (heading),
    .distance_o    (distance)
  );

  assign m_axis_tdata = {1'b0, distance, heading, pos_y, pos_x};

  `DDO_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `DDO_ASSERT_IMP(a_iter_range, cmd.op == OP_CSTEP, cmd.iter < IterWidth'(CordicSteps))
  `DDO_ASSERT_NXT(a_out_load, cmd.op == OP_OUT, m_axis_tvalid)
  `DDO_ASSERT_NXT(a_primed_sticky, status.primed, status.primed)

endmodule

`default_nettype wire

FILE: design/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// Differential drive odometry controller
// Sequences the datapath through multiply, heading, CORDIC and accumulate steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  ddo_pkg::dp_status_t status_i,
  output ddo_pkg::dp_cmd_t    cmd_o
);
  import ddo_pkg::*;

  state_e               state_q, state_d;
  logic [IterWidth-1:0] iter_q, iter_d;
  logic                 valid_q, valid_d;
  logic                 accept;
  logic                 out_load;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_load = (state_q == S_OUT) && (!valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = status_i.primed ? S_MTR : S_OUT;
        end
      end
      S_MTR:   state_d = S_MTL;
      S_MTL:   state_d = S_MVR;
      S_MVR:   state_d = S_MVL;
      S_MVL:   state_d = S_HEAD;
      S_HEAD:  state_d = S_ANGLE;
      S_ANGLE: state_d = S_MRAD;
      S_MRAD:  state_d = S_CINIT;
      S_CINIT: begin
        state_d = S_CSTEP;
        iter_d  = '0;
      end
      S_CSTEP: begin
        if (iter_q == IterWidth'(CordicSteps - 1)) begin
          state_d = S_MXH;
          iter_d  = '0;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      S_MXH:  state_d = S_MXL;
      S_MXL:  state_d = S_MYH;
      S_MYH:  state_d = S_MYL;
      S_MYL:  state_d = S_SUM1;
      S_SUM1: state_d = S_SUM2;
      S_SUM2: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.iter = iter_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = status_i.primed ? OP_LOAD : OP_PRIME;
        end else begin
          cmd_o.op = OP_NONE;
        end
      end
      S_MTR:   cmd_o.op = OP_MTR;
      S_MTL:   cmd_o.op = OP_MTL;
      S_MVR:   cmd_o.op = OP_MVR;
      S_MVL:   cmd_o.op = OP_MVL;
      S_HEAD:  cmd_o.op = OP_HEAD;
      S_ANGLE: cmd_o.op = OP_ANGLE;
      S_MRAD:  cmd_o.op = OP_MRAD;
      S_CINIT: cmd_o.op = OP_CINIT;
      S_CSTEP: cmd_o.op = OP_CSTEP;
      S_MXH:   cmd_o.op = OP_MXH;
      S_MXL:   cmd_o.op = OP_MXL;
      S_MYH:   cmd_o.op = OP_MYH;
      S_MYL:   cmd_o.op = OP_MYL;
      S_SUM1:  cmd_o.op = OP_SUM1;
      S_SUM2:  cmd_o.op = OP_SUM2;
      S_OUT:   cmd_o.op = out_load ? OP_OUT : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ddo_dpath.sv
// ----------------------------------------------------------------------------
// Differential drive odometry datapath
// Configuration registers, shared multiplier, CORDIC stage and accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_dpath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [ddo_pkg::IdxWidth-1:0]         cfg_idx_i,
  input  wire  [ddo_pkg::CfgWidth-1:0]         cfg_data_i,
  input  wire  [31:0]                          left_count_i,
  input  wire  [31:0]                          right_count_i,
  input  ddo_pkg::dp_cmd_t                     cmd_i,
  output ddo_pkg::dp_status_t                  status_o,
  output logic signed [47:0]                   pos_x_o,
  output logic signed [47:0]                   pos_y_o,
  output logic signed [30:0]                   heading_o,
  output logic signed [47:0]                   distance_o
);
  import ddo_pkg::*;

  logic signed [31:0] trav_l_q, trav_r_q, turn_l_q, turn_r_q;
  logic signed [30:0] st_head_q;
  logic signed [47:0] st_x_q, st_y_q;

  logic [CountWidth-1:0]        prev_l_q, prev_r_q;
  logic                         primed_q;
  logic signed [CountWidth-1:0] dl_q, dr_q;
  logic signed [63:0]           p_tr_q, p_tl_q, p_vr_q, p_vl_q;
  logic signed [31:0]           head_q;
  logic signed [33:0]           hold_q;
  logic signed [49:0]           travel_q;
  logic signed [30:0]           ang_q;
  logic                         neg_q;
  logic signed [55:0]           prad_q;
  logic signed [33:0]           cx_q, cy_q;
  logic signed [32:0]           cz_q;
  logic signed [59:0]           pxh_q, pyh_q;
  logic signed [58:0]           pxl_q, pyl_q;
  logic signed [55:0]           dx_q, dy_q;
  logic signed [47:0]           x_q, y_q, dist_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [33:0] cos_v, sin_v;
  logic signed [33:0] trav_hi, trav_lo;

  logic signed [64:0] dh_full, vs_full;
  logic signed [57:0] hn0, hn1, hn2;
  logic signed [33:0] ho0, ho1;
  logic signed [34:0] ang, r0, r1;
  logic               fold;
  logic signed [33:0] sx, sy;
  logic signed [32:0] at;
  logic signed [85:0] dx_full, dy_full;

  assign cos_v   = neg_q ? -cx_q : cx_q;
  assign sin_v   = neg_q ? -cy_q : cy_q;
  assign trav_hi = 34'($signed(travel_q[49:24]));
  assign trav_lo = {10'b0, travel_q[23:0]};

  always_comb begin
    case (cmd_i.op)
      OP_MTR: begin
        mul_a = 34'(turn_r_q);
        mul_b = 34'(dr_q);
      end
      OP_MTL: begin
        mul_a = 34'(turn_l_q);
        mul_b = 34'(dl_q);
      end
      OP_MVR: begin
        mul_a = 34'(trav_r_q);
        mul_b = 34'(dr_q);
      end
      OP_MVL: begin
        mul_a = 34'(trav_l_q);
        mul_b = 34'(dl_q);
      end
      OP_MRAD: begin
        mul_a = 34'(ang_q);
        mul_b = 34'(Deg2RadQ30);
      end
      OP_MXH: begin
        mul_a = trav_hi;
        mul_b = cos_v;
      end
      OP_MXL: begin
        mul_a = trav_lo;
        mul_b = cos_v;
      end
      OP_MYH: begin
        mul_a = trav_hi;
        mul_b = sin_v;
      end
      OP_MYL: begin
        mul_a = trav_lo;
        mul_b = sin_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    dh_full = 65'(p_tr_q) - 65'(p_tl_q);
    vs_full = 65'(p_vr_q) + 65'(p_vl_q);
    hn0     = 58'(head_q) + 58'($signed(dh_full[64:8]));
    ho0     = 34'(head_q);
    if (hn0 > 58'(Deg180)) begin
      hn1 = hn0 - 58'(Deg360);
      ho1 = ho0 - 34'(Deg360);
    end else if (hn0 < -58'(Deg180)) begin
      hn1 = hn0 + 58'(Deg360);
      ho1 = ho0 + 34'(Deg360);
    end else begin
      hn1 = hn0;
      ho1 = ho0;
    end
    if (hn1 > 58'(Deg180)) begin
      hn2 = 58'(Deg180);
    end else if (hn1 < -58'(Deg180)) begin
      hn2 = -58'(Deg180);
    end else begin
      hn2 = hn1;
    end
  end

  always_comb begin
    ang = 35'(head_q) + 35'(hold_q);
    if (ang > 35'(Q23Deg180)) begin
      r0 = ang - 35'(Q23Deg360);
    end else if (ang <= -35'(Q23Deg180)) begin
      r0 = ang + 35'(Q23Deg360);
    end else begin
      r0 = ang;
    end
    if (r0 > 35'(Q23Deg90)) begin
      r1   = r0 - 35'(Q23Deg180);
      fold = 1'b1;
    end else if (r0 < -35'(Q23Deg90)) begin
      r1   = r0 + 35'(Q23Deg180);
      fold = 1'b1;
    end else begin
      r1   = r0;
      fold = 1'b0;
    end
  end

  assign sx = cx_q >>> cmd_i.iter;
  assign sy = cy_q >>> cmd_i.iter;
  assign at = 33'(atan_q30(cmd_i.iter));

  assign dx_full = (86'(pxh_q) <<< 24) + 86'(pxl_q);
  assign dy_full = (86'(pyh_q) <<< 24) + 86'(pyl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trav_l_q  <= -32'sd52553379;
      trav_r_q  <= 32'sd52537826;
      turn_l_q  <= -32'sd11677453;
      turn_r_q  <= 32'sd11659138;
      st_head_q <= '0;
      st_x_q    <= '0;
      st_y_q    <= '0;
      primed_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_TRAVEL_L:   trav_l_q  <= cfg_data_i[31:0];
          REG_TRAVEL_R:   trav_r_q  <= cfg_data_i[31:0];
          REG_TURN_L:     turn_l_q  <= cfg_data_i[31:0];
          REG_TURN_R:     turn_r_q  <= cfg_data_i[31:0];
          REG_START_HEAD: st_head_q <= cfg_data_i[30:0];
          REG_START_X:    st_x_q    <= cfg_data_i[47:0];
          REG_START_Y:    st_y_q    <= cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_PRIME) begin
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_PRIME: begin
        prev_l_q <= left_count_i[CountWidth-1:0];
        prev_r_q <= right_count_i[CountWidth-1:0];
        head_q   <= 32'(st_head_q);
        x_q      <= st_x_q;
        y_q      <= st_y_q;
        dist_q   <= '0;
      end
      OP_LOAD: begin
        dl_q     <= left_count_i[CountWidth-1:0] - prev_l_q;
        dr_q     <= right_count_i[CountWidth-1:0] - prev_r_q;
        prev_l_q <= left_count_i[CountWidth-1:0];
        prev_r_q <= right_count_i[CountWidth-1:0];
      end
      OP_MTR: p_tr_q <= mul_p[63:0];
      OP_MTL: p_tl_q <= mul_p[63:0];
      OP_MVR: p_vr_q <= mul_p[63:0];
      OP_MVL: p_vl_q <= mul_p[63:0];
      OP_HEAD: begin
        head_q   <= 32'(hn2);
        hold_q   <= ho1;
        travel_q <= vs_full[64:15];
      end
      OP_ANGLE: begin
        ang_q <= 31'(r1);
        neg_q <= fold;
      end
      OP_MRAD: prad_q <= mul_p[55:0];
      OP_CINIT: begin
        cz_q <= prad_q[55:23];
        cx_q <= 34'(CordicKinv);
        cy_q <= '0;
      end
      OP_CSTEP: begin
        if (!cz_q[32]) begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          cz_q <= cz_q + at;
        end
      end
      OP_MXH: pxh_q <= mul_p[59:0];
      OP_MXL: pxl_q <= mul_p[58:0];
      OP_MYH: pyh_q <= mul_p[59:0];
      OP_MYL: pyl_q <= mul_p[58:0];
      OP_SUM1: begin
        dx_q <= dx_full[85:30];
        dy_q <= dy_full[85:30];
      end
      OP_SUM2: begin
        x_q    <= sat48(58'(x_q) + 58'(dx_q));
        y_q    <= sat48(58'(y_q) + 58'(dy_q));
        dist_q <= sat48(58'(dist_q) + 58'(travel_q));
      end
      OP_OUT: begin
        pos_x_o    <= x_q;
        pos_y_o    <= y_q;
        heading_o  <= head_q[30:0];
        distance_o <= dist_q;
      end
      default: ;
    endcase
  end

  assign status_o.primed = primed_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives encoder count samples over the input stream and writes the odometry
// coefficients and start pose between phases. A fixed-point predictor tracks
// heading, travel, CORDIC projection and saturating accumulation, and every
// pose transaction is checked field by field against it. Both stream sides
// idle in random bursts except during the final phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ddo_pkg::*;

  localparam logic [IdxWidth-1:0] RegUnused = 3'd7;
  localparam longint Max48 = 64'sh00007FFFFFFFFFFF;
  localparam longint Min48 = -64'sh0000800000000000;
  localparam int SettleCycles = 60;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [30:0] hd;
    logic signed [47:0] distance;
  } pose_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [IdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgWidth-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [175:0]        m_axis_tdata;

  differential_drive_odometry uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  longint travel_l = -52553379, travel_r = 52537826;
  longint turn_l = -11677453, turn_r = 11659138;
  longint start_hd = 0, start_x = 0, start_y = 0;
  logic [31:0] ref_l = '0, ref_r = '0;
  logic   primed = 1'b0;
  longint head_acc = 0, x_acc = 0, y_acc = 0, dist_acc = 0;

  pose_t  expected_poses[$];
  int     errs = 0;
  bit     calm = 1'b0;
  logic [31:0] cur_l = '0, cur_r = '0;

  localparam longint AtanQ30[30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("differential_drive_odometry: mismatch");
    $finish;
  end

  function automatic longint clamp48(logic signed [65:0] v);
    longint r;
    if (v > Max48) r = Max48;
    else if (v < Min48) r = Min48;
    else r = longint'(v);
    return r;
  endfunction

  function automatic longint scale_q30(longint v, longint c);
    logic signed [95:0] m;
    m = v;
    m = m * c;
    m = m >>> 30;
    return longint'(m);
  endfunction

  function automatic pose_t advance_pose(logic [31:0] cl, logic [31:0] cr);
    pose_t p;
    longint dl, dr, dh, trv, hn, ho, r, rad, cx, cy, cz, sx, sy;
    logic signed [65:0] w, hw;
    logic [31:0] diff;
    bit flip;
    flip = 1'b0;
    if (!primed) begin
      primed = 1'b1;
      head_acc = start_hd;
      x_acc = start_x;
      y_acc = start_y;
      dist_acc = 0;
    end else begin
      diff = cl - ref_l;
      dl = longint'($signed(diff));
      diff = cr - ref_r;
      dr = longint'($signed(diff));
      w = turn_r * dr;
      w = w - turn_l * dl;
      dh = longint'(w >>> 8);
      ho = head_acc;
      hw = ho;
      hw = hw + dh;
      if (hw > Deg180) begin
        hw = hw - Deg360;
        ho = ho - Deg360;
      end else if (hw < -Deg180) begin
        hw = hw + Deg360;
        ho = ho + Deg360;
      end
      if (hw > Deg180) hw = Deg180;
      if (hw < -Deg180) hw = -Deg180;
      hn = longint'(hw);
      head_acc = hn;
      w = travel_r * dr;
      w = w + travel_l * dl;
      trv = longint'(w >>> 15);
      r = (hn + ho) % Q23Deg360;
      if (r < 0) r = r + Q23Deg360;
      if (r > Q23Deg180) r = r - Q23Deg360;
      if (r > Q23Deg90) begin
        r = r - Q23Deg180;
        flip = 1'b1;
      end else if (r < -Q23Deg90) begin
        r = r + Q23Deg180;
        flip = 1'b1;
      end
      rad = (r * Deg2RadQ30) >>> 23;
      cx = CordicKinv;
      cy = 0;
      cz = rad;
      for (int i = 0; i < CordicSteps; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cz >= 0) begin
          cx = cx - sy;
          cy = cy + sx;
          cz = cz - AtanQ30[i];
        end else begin
          cx = cx + sy;
          cy = cy - sx;
          cz = cz + AtanQ30[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      w = x_acc;
      x_acc = clamp48(w + scale_q30(trv, cx));
      w = y_acc;
      y_acc = clamp48(w + scale_q30(trv, cy));
      w = dist_acc;
      dist_acc = clamp48(w + trv);
    end
    ref_l = cl;
    ref_r = cr;
    p.x = x_acc[47:0];
    p.y = y_acc[47:0];
    p.hd = head_acc[30:0];
    p.distance = dist_acc[47:0];
    return p;
  endfunction

  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pose_t got, exp_p;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[47:0];
      got.y = m_axis_tdata[95:48];
      got.hd = m_axis_tdata[126:96];
      got.distance = m_axis_tdata[174:127];
      if (expected_poses.size() == 0) begin
        $error("unexpected transaction x=%0d", got.x);
        errs++;
      end else begin
        exp_p = expected_poses.pop_front();
        if (got.x !== exp_p.x) begin
          $error("pos_x expected %0d got %0d", exp_p.x, got.x);
          errs++;
        end
        if (got.y !== exp_p.y) begin
          $error("pos_y expected %0d got %0d", exp_p.y, got.y);
          errs++;
        end
        if (got.hd !== exp_p.hd) begin
          $error("heading expected %0d got %0d", exp_p.hd, got.hd);
          errs++;
        end
        if (got.distance !== exp_p.distance) begin
          $error("distance expected %0d got %0d", exp_p.distance, got.distance);
          errs++;
        end
      end
    end
  end

  task automatic send_counts(input logic [31:0] l, input logic [31:0] r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tdata = {r, l};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_poses.push_back(advance_pose(l, r));
    cur_l = l;
    cur_r = r;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic step_counts(input int dl, input int dr);
    send_counts(cur_l + dl, cur_r + dr);
  endtask

  task automatic drain();
    wait (expected_poses.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [CfgWidth-1:0] d);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = d;
    case (idx)
      REG_TRAVEL_L:   travel_l = longint'($signed(d[31:0]));
      REG_TRAVEL_R:   travel_r = longint'($signed(d[31:0]));
      REG_TURN_L:     turn_l = longint'($signed(d[31:0]));
      REG_TURN_R:     turn_r = longint'($signed(d[31:0]));
      REG_START_HEAD: start_hd = longint'($signed(d[30:0]));
      REG_START_X:    start_x = longint'($signed(d[47:0]));
      REG_START_Y:    start_y = longint'($signed(d[47:0]));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_coeffs(input logic [31:0] tl, input logic [31:0] tr,
                              input logic [31:0] hl, input logic [31:0] hr);
    write_reg(REG_TRAVEL_L, {16'h0, tl});
    write_reg(REG_TRAVEL_R, {16'h0, tr});
    write_reg(REG_TURN_L, {16'h0, hl});
    write_reg(REG_TURN_R, {16'h0, hr});
  endtask

  task automatic test_priming();
    write_reg(REG_START_HEAD, 48'sd754974720);
    write_reg(REG_START_X, 48'h7FFF_FFF0_0000);
    write_reg(REG_START_Y, 48'h8000_0000_1234);
    write_reg(RegUnused, 48'hFFFF_FFFF_FFFF);
    write_coeffs(-32'sd52553379, 32'sd52537826, -32'sd11677453, 32'sd11659138);
    send_counts(32'h7FFF_FFFF, 32'h8000_0000);
    step_counts(0, 0);
    step_counts(1, 1);
    step_counts(1000, 1000);
    step_counts(-3000, -3000);
  endtask

  task automatic test_heading_wrap();
    step_counts(-20000, 20000);
    step_counts(-20000, 20000);
    step_counts(30000, -30000);
    step_counts(30000, -30000);
    step_counts(32'sh7FFF_FFFF, 0);
    step_counts(0, 32'sh7FFF_FFFF);
    step_counts(32'sh8000_0000, 32'sh8000_0000);
    send_counts(32'hFFFF_FFFF, 32'h0000_0000);
    send_counts(32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_extremes();
    drain();
    write_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    step_counts(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    step_counts(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    step_counts(32'sh8000_0000, 32'sh8000_0000);
    step_counts(32'sh8000_0000, 32'sh8000_0000);
    step_counts(32'sh8000_0000, 32'sh8000_0000);
    drain();
    write_coeffs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    step_counts(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    step_counts(-32'sh7FFF_FFFF, -32'sh7FFF_FFFF);
    step_counts(0, 0);
  endtask

  task automatic random_phase(input int items);
    int kind;
    for (int n = 0; n < items; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) step_counts($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048);
      else if (kind < 7) step_counts($urandom_range(0, 131070) - 65535,
                                     $urandom_range(0, 131070) - 65535);
      else if (kind == 7) send_counts($urandom, $urandom);
      else if (kind == 8) step_counts($urandom, 0);
      else step_counts(0, 0);
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph % 3)
        0: write_coeffs(-32'sd52553379 + $urandom_range(0, 65535),
                        32'sd52537826 - $urandom_range(0, 65535),
                        -32'sd11677453 + $urandom_range(0, 65535),
                        32'sd11659138 - $urandom_range(0, 65535));
        1: write_coeffs($urandom, $urandom, $urandom, $urandom);
        default: write_coeffs($urandom_range(0, 32'h3FF_FFFF) - 32'h1FF_FFFF,
                              $urandom_range(0, 32'h3FF_FFFF) - 32'h1FF_FFFF,
                              $urandom_range(0, 32'h3FF_FFFF) - 32'h1FF_FFFF,
                              $urandom_range(0, 32'h3FF_FFFF) - 32'h1FF_FFFF);
      endcase
      write_reg(REG_START_HEAD, {16'h0, $urandom_range(0, 32'd1509949440)} - 48'd754974720);
      write_reg(REG_START_X, {$urandom, $urandom});
      write_reg(REG_START_Y, {$urandom, $urandom});
      if (ph == 6) calm = 1'b1;
      random_phase(250);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_priming();
    test_heading_wrap();
    test_extremes();
    test_random();
    wait (expected_poses.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (errs == 0) begin
      $display("differential_drive_odometry: match");
    end else begin
      $display("differential_drive_odometry: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
